FILE: src/rwe_pkg.sv
// shared constants, types and functions for the reflash word encoder
// no dependencies
`timescale 1ns / 1ps

package rwe_pkg;

  localparam int unsigned CountW     = 25;
  localparam int unsigned WordW      = 16;
  localparam int unsigned CodeW      = 19;
  localparam int unsigned KeyBase    = 9744;
  localparam int unsigned CodeMod    = 380951;
  localparam int unsigned CodeInv    = 62135;
  localparam int unsigned QueueDepth = 2;

  localparam logic [17:0] BitW [16] = '{
    18'h00007, 18'h0000F, 18'h00017, 18'h0002F,
    18'h0005D, 18'h000BA, 18'h00174, 18'h002E8,
    18'h005D0, 18'h00BA0, 18'h01740, 18'h02E80,
    18'h05D00, 18'h0BA00, 18'h17401, 18'h2E801
  };

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // bit weight already multiplied by the inverse of the code multiplier
  function automatic logic [CodeW-1:0] code_weight(input int idx);
    logic [63:0] prod;
    prod = 64'(BitW[idx]) * 64'(CodeInv);
    return CodeW'(prod % 64'(CodeMod));
  endfunction

  function automatic logic [CodeW-1:0] mod_add(input logic [CodeW-1:0] a,
                                               input logic [CodeW-1:0] b);
    logic [CodeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (CodeW+1)'(CodeMod)) begin
      return CodeW'(s - (CodeW+1)'(CodeMod));
    end
    return s[CodeW-1:0];
  endfunction

endpackage

FILE: src/rwe_front.sv
// front end: count register, key derivation and word mixing
// depends on rwe_pkg
`timescale 1ns / 1ps

module rwe_front import rwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_total_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        first_byte_i,
  input  logic [7:0]        second_byte_i,
  input  q_stat_t           q_stat_i,
  output logic              push_o,
  output logic [WordW-1:0]  push_data_o
);

  logic [CountW-1:0] total_count_q;
  logic [9:0]        byte_sum;
  logic [WordW-1:0]  key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_count_q <= '0;
    end else if (cfg_we_i) begin
      total_count_q <= cfg_total_count_i;
    end
  end

  assign byte_sum = 10'(total_count_q[7:0]) + 10'(total_count_q[15:8])
                  + 10'(total_count_q[23:16]) + 10'(total_count_q[24]);
  assign key = ~(WordW'(KeyBase) + WordW'(byte_sum));

  assign in_stall_o  = q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;
  assign push_data_o = {second_byte_i, first_byte_i} + key;

endmodule

FILE: src/rwe_queue.sv
// short queue of mixed words between front and back
// depends on rwe_pkg
`timescale 1ns / 1ps

module rwe_queue import rwe_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WordW-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WordW-1:0] head_data_o,
  output q_stat_t          stat_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [WordW-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_data_o  = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

endmodule

FILE: src/rwe_back.sv
// back end: weighted modular sum tree and output register
// depends on rwe_pkg
`timescale 1ns / 1ps

module rwe_back import rwe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_stat_t          q_stat_i,
  input  logic [WordW-1:0] head_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] code_o
);

  logic [CodeW-1:0] sel [16];
  logic [CodeW-1:0] lvl1_q [8], lvl1_d [8];
  logic [CodeW-1:0] lvl2_q [4], lvl2_d [4];
  logic [CodeW-1:0] lvl3_q [2], lvl3_d [2];
  logic [CodeW-1:0] code_q, code_d;
  logic             v1_q, v2_q, v3_q, vo_q;
  logic             rdy1, rdy2, rdy3, rdy_out;

  for (genvar gi = 0; gi < 16; gi++) begin : g_sel
    localparam logic [CodeW-1:0] Weight = code_weight(gi);
    assign sel[gi] = head_data_i[gi] ? Weight : '0;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lvl1_d[i] = mod_add(sel[2*i], sel[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      lvl2_d[i] = mod_add(lvl1_q[2*i], lvl1_q[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl3_d[i] = mod_add(lvl2_q[2*i], lvl2_q[2*i+1]);
    end
    code_d = mod_add(lvl3_q[0], lvl3_q[1]);
  end

  assign rdy_out = !vo_q || !out_stall_i;
  assign rdy3    = !v3_q || rdy_out;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign pop_o   = !q_stat_i.empty && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= pop_o;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_out) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lvl1_q <= lvl1_d;
    end
    if (rdy2 && v1_q) begin
      lvl2_q <= lvl2_d;
    end
    if (rdy3 && v2_q) begin
      lvl3_q <= lvl3_d;
    end
    if (rdy_out && v3_q) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = vo_q;
  assign code_o      = code_q;

endmodule

FILE: src/reflash_word_encoder.sv
// top level of the reflash word encoder: front end, queue and back end
// depends on rwe_pkg, rwe_front, rwe_queue, rwe_back
//
//   channel  direction  handshake                   payload
//   cfg      in         cfg_we_i                    cfg_total_count_i[24:0]
//   in       in         in_valid_i / in_stall_o     first_byte_i, second_byte_i
//   out      out        out_valid_o / out_stall_i   code_low_o, code_mid_o, code_high_o
//
// one transaction per cycle sustained while the output is not stalled; an accepted input
// passes the queue write, three registered modular adder levels and the output register
// reset clears the count register, queue pointers and all stage valid bits
// an output stall freezes the stages behind it; bubbles collapse, the queue
// absorbs the rest and then stalls the input
`timescale 1ns / 1ps

module reflash_word_encoder import rwe_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_total_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        first_byte_i,
  input  logic [7:0]        second_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        code_low_o,
  output logic [7:0]        code_mid_o,
  output logic [2:0]        code_high_o
);

  q_stat_t          q_stat;
  logic             push, pop;
  logic [WordW-1:0] push_data, head_data;
  logic [CodeW-1:0] code;

  rwe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_total_count_i (cfg_total_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .first_byte_i      (first_byte_i),
    .second_byte_i     (second_byte_i),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  rwe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_data_o (head_data),
    .stat_o      (q_stat)
  );

  rwe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_data_i (head_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_o      (code)
  );

  assign code_low_o  = code[7:0];
  assign code_mid_o  = code[15:8];
  assign code_high_o = code[18:16];

  a_code_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({code_high_o, code_mid_o, code_low_o} < CodeW'(CodeMod)))
    else $error("encoded value out of range");

  a_accept_fills_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: verif/reflash_word_encoder_test.sv
// self-checking testbench for the reflash word encoder: directed and random words
// under several total counts, with random input gaps and output stalls
// depends on rwe_pkg and reflash_word_encoder
`timescale 1ns / 1ps

module reflash_word_encoder_test;

  localparam int unsigned PlainKeyBase   = 9744;
  localparam longint      CodeModulus    = 380951;
  localparam longint      CodeMultiplier = 3182;
  localparam int unsigned RandomWords    = 1250;
  localparam int unsigned CountPhases    = 6;
  localparam logic [rwe_pkg::CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [7:0] low;
    logic [7:0] mid;
    logic [2:0] high;
  } code_t;

  logic                       clk_i             = 1'b0;
  logic                       rst_ni            = 1'b0;
  logic                       cfg_we_i          = 1'b0;
  logic [rwe_pkg::CountW-1:0] cfg_total_count_i = '0;
  logic                       in_valid_i        = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 first_byte_i      = '0;
  logic [7:0]                 second_byte_i     = '0;
  logic                       out_valid_o;
  logic                       out_stall_i       = 1'b0;
  logic [7:0]                 code_low_o;
  logic [7:0]                 code_mid_o;
  logic [2:0]                 code_high_o;

  logic [rwe_pkg::CountW-1:0] count_shadow = '0;
  code_t                      pending_codes[$];
  int unsigned                fail_count   = 0;
  int unsigned                burst_left   = 0;
  int unsigned                stall_left   = 0;
  int unsigned                stall_mode   = 0;

  reflash_word_encoder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_total_count_i (cfg_total_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .first_byte_i      (first_byte_i),
    .second_byte_i     (second_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .code_low_o        (code_low_o),
    .code_mid_o        (code_mid_o),
    .code_high_o       (code_high_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned bit_weight(input int idx);
    case (idx)
      0:       return 32'h00007;
      1:       return 32'h0000F;
      2:       return 32'h00017;
      3:       return 32'h0002F;
      4:       return 32'h0005D;
      5:       return 32'h000BA;
      6:       return 32'h00174;
      7:       return 32'h002E8;
      8:       return 32'h005D0;
      9:       return 32'h00BA0;
      10:      return 32'h01740;
      11:      return 32'h02E80;
      12:      return 32'h05D00;
      13:      return 32'h0BA00;
      14:      return 32'h17401;
      default: return 32'h2E801;
    endcase
  endfunction

  // extended euclid, operands coprime
  function automatic longint inverse_mod(input longint a, input longint m);
    longint t, nt, r, nr, q, tmp;
    t  = 0;
    nt = 1;
    r  = m;
    nr = a % m;
    while (nr != 0) begin
      q   = r / nr;
      tmp = t - q * nt;
      t   = nt;
      nt  = tmp;
      tmp = r - q * nr;
      r   = nr;
      nr  = tmp;
    end
    if (t < 0) begin
      t += m;
    end
    return t;
  endfunction

  function automatic logic [15:0] word_key(input logic [rwe_pkg::CountW-1:0] count);
    int unsigned byte_sum;
    byte_sum = 32'(count[7:0]) + 32'(count[15:8]) + 32'(count[23:16]) + 32'(count[24]);
    return ~16'(PlainKeyBase + byte_sum);
  endfunction

  function automatic code_t encode_word(input logic [rwe_pkg::CountW-1:0] count,
                                        input logic [7:0] first, input logic [7:0] second);
    logic [15:0] mixed;
    int unsigned total;
    longint      code;
    code_t       res;
    mixed = {second, first} + word_key(count);
    total = 0;
    for (int i = 0; i < 16; i++) begin
      if (mixed[i]) begin
        total += bit_weight(i);
      end
    end
    code     = (longint'(total) * inverse_mod(CodeMultiplier, CodeModulus)) % CodeModulus;
    res.low  = code[7:0];
    res.mid  = code[15:8];
    res.high = code[18:16];
    return res;
  endfunction

  // results are checked before this edge's input transaction is queued
  always @(posedge clk_i) begin : scoreboard
    code_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_codes.size() == 0) begin
          $error("result with no transaction pending: %h %h %h",
                 code_high_o, code_mid_o, code_low_o);
          fail_count++;
        end else begin
          want = pending_codes.pop_front();
          if (code_low_o !== want.low) begin
            $error("code_low: expected %h, actual %h", want.low, code_low_o);
            fail_count++;
          end
          if (code_mid_o !== want.mid) begin
            $error("code_mid: expected %h, actual %h", want.mid, code_mid_o);
            fail_count++;
          end
          if (code_high_o !== want.high) begin
            $error("code_high: expected %h, actual %h", want.high, code_high_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_codes.insert(pending_codes.size(),
                             encode_word(count_shadow, first_byte_i, second_byte_i));
      end
    end
  end

  always @(negedge clk_i) begin : stall_pattern
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= stall_left[2];
    endcase
  end

  // entered and left at a falling edge
  task automatic send_word(input logic [7:0] first, input logic [7:0] second);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    first_byte_i  <= first;
    second_byte_i <= second;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_count(input logic [rwe_pkg::CountW-1:0] value);
    wait_drained();
    cfg_total_count_i <= value;
    cfg_we_i          <= 1'b1;
    count_shadow       = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // byte extremes plus words that force the mixed value to none, all and single bits
  task automatic send_edge_words();
    logic [15:0] key;
    logic [15:0] word;
    logic [15:0] targets [5];
    key        = word_key(count_shadow);
    targets[0] = 16'h0000;
    targets[1] = 16'hFFFF;
    targets[2] = 16'h0001;
    targets[3] = 16'h4000;
    targets[4] = 16'h8000;
    send_word(8'h00, 8'h00);
    send_word(8'hFF, 8'hFF);
    send_word(8'hFF, 8'h00);
    send_word(8'h00, 8'hFF);
    foreach (targets[i]) begin
      word = targets[i] - key;
      send_word(word[7:0], word[15:8]);
    end
  endtask

  task automatic test_reset_count();
    send_edge_words();
    wait_drained();
  endtask

  task automatic test_max_count();
    write_count(CountMax);
    send_edge_words();
    wait_drained();
  endtask

  task automatic test_random_words();
    logic [rwe_pkg::CountW-1:0] count;
    logic [7:0]                 first, second;
    for (int p = 0; p < CountPhases; p++) begin
      case (p)
        0:       count = '0;
        1:       count = CountMax;
        2:       count = 25'h0FFFFFF;
        3:       count = 25'h1000000;
        default: count = rwe_pkg::CountW'($urandom);
      endcase
      write_count(count);
      for (int n = 0; n < RandomWords / CountPhases; n++) begin
        first  = 8'($urandom);
        second = 8'($urandom);
        case ($urandom_range(0, 9))
          0:       first = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
          1:       second = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
          default: ;
        endcase
        send_word(first, second);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_count();
    test_max_count();
    test_random_words();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
src/rwe_pkg.sv
src/rwe_front.sv
src/rwe_queue.sv
src/rwe_back.sv
src/reflash_word_encoder.sv
verif/reflash_word_encoder_test.sv
